// ===== hw/rtl/nat_pkg.sv =====
// Shared types, codes and reset constants of the NAT translation table.
package nat_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [15:0] ICMP_TIMEOUT_RST = 16'd60;
  localparam logic [15:0] PORT_LOW_RST     = 16'd1024;
  localparam logic [15:0] PORT_HIGH_RST    = 16'hFFFF;
  localparam logic [31:0] EXT_IP_RST       = 32'd0;

  // An unsolicited mapping carries this internal port and a zero address.
  localparam logic [15:0] UNSOL_INT_AUX = 16'd1;

  localparam logic KIND_ICMP = 1'b0;
  localparam logic KIND_TCP  = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOOKUP_INT   = 3'd0,
    CMD_LOOKUP_EXT   = 3'd1,
    CMD_INSERT       = 3'd2,
    CMD_INSERT_UNSOL = 3'd3,
    CMD_REFRESH      = 3'd4,
    CMD_TICK         = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NO_PORT = 2'd3
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ICMP_TIMEOUT = 2'd0,
    REG_PORT_LOW     = 2'd1,
    REG_PORT_HIGH    = 2'd2,
    REG_EXTERNAL_IP  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_RD,
    S_CMP,
    S_WR
  } fsm_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        kind;
    logic [31:0] int_ip;
    logic [15:0] int_aux;
    logic [15:0] ext_aux;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_int_ip;
    logic [15:0] found_int_aux;
    logic [15:0] found_ext_aux;
    logic [31:0] found_ext_ip;
    logic [6:0]  removed_count;
  } rsp_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] int_ip;
    logic [15:0] int_aux;
    logic [15:0] ext_aux;
    logic [31:0] seen_time;
  } entry_t;

endpackage

// ===== hw/rtl/nat_mapping_table_unit.sv =====
// NAT translation table: command sequencer, valid bits and configuration registers.
//
// A command is taken when start is high and busy is low; busy then stays high
// until the cycle in which the single result is shown, and an unused command
// code never raises it. The result appears on rsp for one cycle with done high
// and must be taken then: the receiver cannot stall.
// Configuration registers are written over cfg_valid/cfg_ready with an index
// and data; cfg_ready is high whenever no command is in progress.
// Lookups, refresh, tick and TCP inserts walk the table through the one read
// port of the table RAM, an address step and then a compare of the registered
// read data for each entry. Lookups and refresh stop at the first match; a tick
// always walks the whole table. Inserts first search the valid bits for a free
// slot, one entry a cycle; a TCP insert then scans the table once per candidate
// port until it finds a free port or has tested every port of the range. Unused
// command codes finish with a miss result and walk nothing. After reset every
// mapping is invalid, time is zero and the next candidate port is the reset value
// of port_low; no clearing pass is needed.
module nat_mapping_table_unit #(
  parameter int ENTRIES = nat_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  nat_pkg::req_t                  req,
  output logic                           done,
  output nat_pkg::rsp_t                  rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int RW = $clog2(ENTRIES + 1);

  nat_pkg::fsm_t   state, state_next;
  nat_pkg::req_t   req_q;
  nat_pkg::entry_t rd_entry, wr_entry;
  nat_pkg::rsp_t   fin_rsp;

  logic [IW-1:0]      idx, slot, wr_addr;
  logic [15:0]        cand, next_port, icmp_timeout, port_low, port_high;
  logic [31:0]        external_ip, now_time;
  logic [16:0]        tries, span;
  logic [RW-1:0]      removed;
  logic [ENTRIES-1:0] valid;
  logic               wr_en, fin, accept, last, vbit, is_tcp_ins;
  logic               m_int, m_ext, m_port, m_age;
  logic [15:0]        cand_wrap, start_cand;

  assign busy      = (state != nat_pkg::S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  assign last       = (idx == IW'(ENTRIES - 1));
  assign vbit       = valid[idx];
  assign is_tcp_ins = (req_q.cmd == nat_pkg::CMD_INSERT) && (req_q.kind == nat_pkg::KIND_TCP);
  assign span       = {1'b0, port_high} - {1'b0, port_low} + 17'd1;
  assign cand_wrap  = (cand >= port_high) ? port_low : cand + 16'd1;
  assign start_cand = (next_port < port_low || next_port > port_high) ? port_low : next_port;

  assign m_int  = vbit && rd_entry.kind == req_q.kind && rd_entry.int_ip == req_q.int_ip
                  && rd_entry.int_aux == req_q.int_aux;
  assign m_ext  = vbit && rd_entry.kind == req_q.kind && rd_entry.ext_aux == req_q.ext_aux;
  assign m_port = vbit && rd_entry.kind == nat_pkg::KIND_TCP && rd_entry.ext_aux == cand;
  assign m_age  = vbit && rd_entry.kind == nat_pkg::KIND_ICMP
                  && (now_time - rd_entry.seen_time) >= {16'd0, icmp_timeout};

  nat_tbl_ram #(
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (idx),
    .rdata (rd_entry)
  );

  always_comb begin
    state_next = state;
    case (state)
      nat_pkg::S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            nat_pkg::CMD_LOOKUP_INT, nat_pkg::CMD_LOOKUP_EXT,
            nat_pkg::CMD_REFRESH, nat_pkg::CMD_TICK:     state_next = nat_pkg::S_RD;
            nat_pkg::CMD_INSERT, nat_pkg::CMD_INSERT_UNSOL: state_next = nat_pkg::S_FREE;
            default:                                     state_next = nat_pkg::S_IDLE;
          endcase
        end
      end
      nat_pkg::S_FREE: begin
        if (!vbit) begin
          if (is_tcp_ins) begin
            state_next = (port_low > port_high) ? nat_pkg::S_IDLE : nat_pkg::S_RD;
          end else begin
            state_next = nat_pkg::S_WR;
          end
        end else if (last) begin
          state_next = nat_pkg::S_IDLE;
        end
      end
      nat_pkg::S_RD: state_next = nat_pkg::S_CMP;
      nat_pkg::S_CMP: begin
        case (req_q.cmd)
          nat_pkg::CMD_LOOKUP_INT, nat_pkg::CMD_REFRESH:
            state_next = (m_int || last) ? nat_pkg::S_IDLE : nat_pkg::S_RD;
          nat_pkg::CMD_LOOKUP_EXT:
            state_next = (m_ext || last) ? nat_pkg::S_IDLE : nat_pkg::S_RD;
          nat_pkg::CMD_TICK:
            state_next = last ? nat_pkg::S_IDLE : nat_pkg::S_RD;
          nat_pkg::CMD_INSERT: begin
            if (m_port) begin
              state_next = (tries + 17'd1 == span) ? nat_pkg::S_IDLE : nat_pkg::S_RD;
            end else begin
              state_next = last ? nat_pkg::S_WR : nat_pkg::S_RD;
            end
          end
          default: state_next = nat_pkg::S_IDLE;
        endcase
      end
      nat_pkg::S_WR: state_next = nat_pkg::S_IDLE;
      default:       state_next = nat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    fin      = 1'b0;
    fin_rsp  = '0;
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_entry = rd_entry;
    fin_rsp.status = nat_pkg::STAT_MISS;
    case (state)
      nat_pkg::S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            nat_pkg::CMD_LOOKUP_INT, nat_pkg::CMD_LOOKUP_EXT, nat_pkg::CMD_INSERT,
            nat_pkg::CMD_INSERT_UNSOL, nat_pkg::CMD_REFRESH, nat_pkg::CMD_TICK: fin = 1'b0;
            default: fin = 1'b1;
          endcase
        end
      end
      nat_pkg::S_FREE: begin
        if (!vbit && is_tcp_ins && port_low > port_high) begin
          fin            = 1'b1;
          fin_rsp.status = nat_pkg::STAT_NO_PORT;
        end else if (vbit && last) begin
          fin            = 1'b1;
          fin_rsp.status = nat_pkg::STAT_FULL;
        end
      end
      nat_pkg::S_CMP: begin
        case (req_q.cmd)
          nat_pkg::CMD_LOOKUP_INT, nat_pkg::CMD_LOOKUP_EXT, nat_pkg::CMD_REFRESH: begin
            if ((req_q.cmd == nat_pkg::CMD_LOOKUP_EXT) ? m_ext : m_int) begin
              fin                   = 1'b1;
              fin_rsp.status        = nat_pkg::STAT_OK;
              fin_rsp.found_int_ip  = rd_entry.int_ip;
              fin_rsp.found_int_aux = rd_entry.int_aux;
              fin_rsp.found_ext_aux = rd_entry.ext_aux;
              fin_rsp.found_ext_ip  = external_ip;
              if (req_q.cmd == nat_pkg::CMD_REFRESH) begin
                wr_en              = 1'b1;
                wr_entry.seen_time = now_time;
              end
            end else if (last) begin
              fin = 1'b1;
            end
          end
          nat_pkg::CMD_TICK: begin
            if (last) begin
              fin                   = 1'b1;
              fin_rsp.status        = nat_pkg::STAT_OK;
              fin_rsp.removed_count = 7'(removed + RW'(m_age));
            end
          end
          nat_pkg::CMD_INSERT: begin
            if (m_port && tries + 17'd1 == span) begin
              fin            = 1'b1;
              fin_rsp.status = nat_pkg::STAT_NO_PORT;
            end
          end
          default: fin = 1'b0;
        endcase
      end
      nat_pkg::S_WR: begin
        wr_en              = 1'b1;
        wr_addr            = slot;
        wr_entry.kind      = req_q.kind;
        wr_entry.seen_time = now_time;
        if (req_q.cmd == nat_pkg::CMD_INSERT_UNSOL) begin
          wr_entry.int_ip  = '0;
          wr_entry.int_aux = nat_pkg::UNSOL_INT_AUX;
          wr_entry.ext_aux = req_q.ext_aux;
        end else begin
          wr_entry.int_ip  = req_q.int_ip;
          wr_entry.int_aux = req_q.int_aux;
          wr_entry.ext_aux = (req_q.kind == nat_pkg::KIND_ICMP) ? req_q.int_aux : cand;
        end
        fin                   = 1'b1;
        fin_rsp.status        = nat_pkg::STAT_OK;
        fin_rsp.found_int_ip  = wr_entry.int_ip;
        fin_rsp.found_int_aux = wr_entry.int_aux;
        fin_rsp.found_ext_aux = wr_entry.ext_aux;
        fin_rsp.found_ext_ip  = external_ip;
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nat_pkg::S_IDLE;
      done         <= 1'b0;
      valid        <= '0;
      now_time     <= '0;
      next_port    <= nat_pkg::PORT_LOW_RST;
      icmp_timeout <= nat_pkg::ICMP_TIMEOUT_RST;
      port_low     <= nat_pkg::PORT_LOW_RST;
      port_high    <= nat_pkg::PORT_HIGH_RST;
      external_ip  <= nat_pkg::EXT_IP_RST;
    end else begin
      state <= state_next;
      done  <= fin;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nat_pkg::REG_ICMP_TIMEOUT: icmp_timeout <= cfg_data[15:0];
          nat_pkg::REG_PORT_LOW:     port_low     <= cfg_data[15:0];
          nat_pkg::REG_PORT_HIGH:    port_high    <= cfg_data[15:0];
          nat_pkg::REG_EXTERNAL_IP:  external_ip  <= cfg_data;
          default:                   external_ip  <= external_ip;
        endcase
      end
      if (state == nat_pkg::S_IDLE && accept && req.cmd == nat_pkg::CMD_TICK) begin
        now_time <= now_time + 32'd1;
      end
      if (state == nat_pkg::S_CMP && req_q.cmd == nat_pkg::CMD_TICK && m_age) begin
        valid[idx] <= 1'b0;
      end
      if (state == nat_pkg::S_WR) begin
        valid[slot] <= 1'b1;
        if (is_tcp_ins) begin
          next_port <= cand_wrap;
        end
      end
    end
  end

  // Payload and scan registers need no reset.
  always_ff @(posedge clk) begin
    if (fin) begin
      rsp <= fin_rsp;
    end
    case (state)
      nat_pkg::S_IDLE: begin
        if (accept) begin
          req_q   <= req;
          idx     <= '0;
          removed <= '0;
        end
      end
      nat_pkg::S_FREE: begin
        if (!vbit) begin
          slot  <= idx;
          cand  <= start_cand;
          tries <= '0;
          idx   <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      nat_pkg::S_CMP: begin
        // A port held by a TCP mapping moves the search to the next candidate.
        if (req_q.cmd == nat_pkg::CMD_INSERT && m_port) begin
          cand  <= cand_wrap;
          tries <= tries + 17'd1;
          idx   <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
        if (req_q.cmd == nat_pkg::CMD_TICK && m_age) begin
          removed <= removed + 1'b1;
        end
      end
      default: idx <= idx;
    endcase
  end

endmodule

// ===== hw/rtl/nat_tbl_ram.sv =====
// Mapping table storage: one write port and one registered read port.
module nat_tbl_ram #(
  parameter int DEPTH = nat_pkg::ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  nat_pkg::entry_t  wdata,
  input  logic [AW-1:0]    raddr,
  output nat_pkg::entry_t  rdata
);

  nat_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
